>>> rtl/core/iee_pkg.sv
// Shared types and constants of the infix expression evaluator.
// Character codes, the character class decoder and the controller-datapath
// command and status structs. No dependencies.
`default_nettype none

package iee_pkg;

  localparam int unsigned CHAR_WIDTH   = 8;
  localparam int unsigned RESULT_WIDTH = 32;

  localparam logic [CHAR_WIDTH-1:0] CHAR_MUL    = 8'h2A;  // '*'
  localparam logic [CHAR_WIDTH-1:0] CHAR_DIV    = 8'h2F;  // '/'
  localparam logic [CHAR_WIDTH-1:0] CHAR_ADD    = 8'h2B;  // '+'
  localparam logic [CHAR_WIDTH-1:0] CHAR_SUB    = 8'h2D;  // '-'
  localparam logic [CHAR_WIDTH-1:0] CHAR_EQUALS = 8'h3D;  // '='
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 8'h39;  // '9'

  // pending operator codes
  localparam logic TERM_OP_MUL = 1'b0;
  localparam logic TERM_OP_DIV = 1'b1;
  localparam logic SUM_OP_ADD  = 1'b0;
  localparam logic SUM_OP_SUB  = 1'b1;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_MUL,
    CLS_DIV,
    CLS_ADD,
    CLS_SUB,
    CLS_EQUALS
  } iee_class_e;

  typedef struct packed {
    logic digit_en;     // shift a digit into the current number
    logic load_term;    // first operand of a term: term = number
    logic md_start;     // start the multiply / divide unit
    logic md_finish;    // take the unit result into the term
    logic set_term_op;
    logic term_op;
    logic sum_en;       // fold the term into the running sum
    logic set_sum_op;
    logic sum_op;
    logic emit;         // load the output word and clear the expression
  } iee_cmd_t;

  typedef struct packed {
    iee_class_e in_class;
    logic       term_started;
    logic       md_done;
    logic       out_busy;
  } iee_status_t;

  function automatic iee_class_e classify(logic [CHAR_WIDTH-1:0] c);
    iee_class_e cls;
    cls = CLS_OTHER;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      cls = CLS_DIGIT;
    end else begin
      case (c)
        CHAR_MUL:    cls = CLS_MUL;
        CHAR_DIV:    cls = CLS_DIV;
        CHAR_ADD:    cls = CLS_ADD;
        CHAR_SUB:    cls = CLS_SUB;
        CHAR_EQUALS: cls = CLS_EQUALS;
        default:     cls = CLS_OTHER;
      endcase
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/iee_muldiv.sv
// Shared iterative multiply / signed divide unit, one bit per cycle.
// Shift-add multiply on the raw operands and restoring divide on magnitudes. Depends on nothing.
`default_nettype none

module iee_muldiv #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         div_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic              done_o,
  output logic              div_zero_o,
  output logic [W-1:0]      result_o
);

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            div_q, neg_q, dz_q;
  logic [W-1:0]    a_q, b_q;
  logic [W-1:0]    acc_q;

  logic [W-1:0]    a_abs, b_abs;
  logic [W-1:0]    a_n, b_n;
  logic [W-1:0]    acc_n;
  logic [W:0]      rem_sh;
  logic            rem_ge;

  assign a_abs = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign b_abs = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  always_comb begin
    rem_sh = {acc_q, b_q[W-1]};
    rem_ge = (rem_sh >= {1'b0, a_q});
    if (div_q) begin
      // remainder stays below the divisor, so it fits in W bits
      acc_n = rem_ge ? W'(rem_sh - {1'b0, a_q}) : rem_sh[W-1:0];
      b_n   = {b_q[W-2:0], rem_ge};
      a_n   = a_q;
    end else begin
      acc_n = acc_q + (b_q[0] ? a_q : {W{1'b0}});
      b_n   = b_q >> 1;
      a_n   = a_q << 1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      if (div_i && (b_i == '0)) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = CntW'(W - 1);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      acc_q <= '0;
      if (div_i) begin
        a_q   <= b_abs;
        b_q   <= (b_i == '0) ? '1 : a_abs;
        neg_q <= (b_i != '0) && (a_i[W-1] ^ b_i[W-1]);
        dz_q  <= (b_i == '0);
      end else begin
        a_q   <= a_i;
        b_q   <= b_i;
        neg_q <= 1'b0;
        dz_q  <= 1'b0;
      end
    end else if (busy_q) begin
      a_q   <= a_n;
      b_q   <= b_n;
      acc_q <= acc_n;
    end
  end

  always_comb begin
    if (!div_q) begin
      result_o = acc_q;
    end else if (neg_q) begin
      result_o = ~b_q + W'(1);
    end else begin
      result_o = b_q;
    end
  end

  assign done_o     = done_q;
  assign div_zero_o = dz_q;

endmodule

`default_nettype wire

>>> rtl/core/iee_datapath.sv
// Datapath of the expression evaluator: number, term and sum registers,
// the output word register and the shared multiply / divide unit.
// Depends on iee_pkg and iee_muldiv.
`default_nettype none

module iee_datapath #(
  parameter int unsigned W = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire iee_pkg::iee_cmd_t                     cmd_i,
  input  wire logic [iee_pkg::CHAR_WIDTH-1:0]        char_i,
  input  wire logic                                  m_tready_i,
  output iee_pkg::iee_status_t                       status_o,
  output logic                                       m_tvalid_o,
  output logic [iee_pkg::RESULT_WIDTH-1:0]           m_tdata_o,
  output logic                                       m_tuser_o
);

  logic [W-1:0] sum_q, term_q, num_q;
  logic         started_q, term_op_q, sum_op_q, err_q;
  logic         out_valid_q;
  logic [iee_pkg::RESULT_WIDTH-1:0] out_value_q;
  logic         out_err_q;

  logic [3:0]   digit_off;
  logic [W-1:0] num_next, sum_next;
  logic [iee_pkg::RESULT_WIDTH-1:0] sum_ext;
  logic         md_done, md_dz;
  logic [W-1:0] md_result;

  assign digit_off = 4'(char_i - iee_pkg::CHAR_ZERO);
  assign num_next  = (num_q << 3) + (num_q << 1) + W'(digit_off);
  assign sum_next  = (sum_op_q == iee_pkg::SUM_OP_SUB) ? (sum_q - term_q) : (sum_q + term_q);

  generate
    if (W >= iee_pkg::RESULT_WIDTH) begin : g_cut
      assign sum_ext = sum_q[iee_pkg::RESULT_WIDTH-1:0];
    end else begin : g_sext
      assign sum_ext = {{(iee_pkg::RESULT_WIDTH - W){sum_q[W-1]}}, sum_q};
    end
  endgenerate

  iee_muldiv #(
    .W(W)
  ) u_muldiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.md_start),
    .div_i      (term_op_q == iee_pkg::TERM_OP_DIV),
    .a_i        (term_q),
    .b_i        (num_q),
    .done_o     (md_done),
    .div_zero_o (md_dz),
    .result_o   (md_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      term_q    <= '0;
      num_q     <= '0;
      started_q <= 1'b0;
      term_op_q <= iee_pkg::TERM_OP_MUL;
      sum_op_q  <= iee_pkg::SUM_OP_ADD;
      err_q     <= 1'b0;
    end else if (cmd_i.emit) begin
      sum_q     <= '0;
      term_q    <= '0;
      num_q     <= '0;
      started_q <= 1'b0;
      term_op_q <= iee_pkg::TERM_OP_MUL;
      sum_op_q  <= iee_pkg::SUM_OP_ADD;
      err_q     <= 1'b0;
    end else begin
      if (cmd_i.digit_en) begin
        num_q <= num_next;
      end
      if (cmd_i.load_term) begin
        term_q    <= num_q;
        started_q <= 1'b1;
        num_q     <= '0;
      end
      if (cmd_i.md_finish) begin
        term_q    <= md_result;
        started_q <= 1'b1;
        num_q     <= '0;
        err_q     <= err_q | md_dz;
      end
      if (cmd_i.set_term_op) begin
        term_op_q <= cmd_i.term_op;
      end
      if (cmd_i.sum_en) begin
        sum_q     <= sum_next;
        term_q    <= '0;
        started_q <= 1'b0;
        term_op_q <= iee_pkg::TERM_OP_MUL;
      end
      if (cmd_i.set_sum_op) begin
        sum_op_q <= cmd_i.sum_op;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= sum_ext;
      out_err_q   <= err_q;
    end
  end

  always_comb begin
    status_o.in_class     = iee_pkg::classify(char_i);
    status_o.term_started = started_q;
    status_o.md_done      = md_done;
    status_o.out_busy     = out_valid_q & ~m_tready_i;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_value_q;
  assign m_tuser_o  = out_err_q;

endmodule

`default_nettype wire

>>> rtl/core/iee_ctrl.sv
// Controller of the expression evaluator: sequences each character through
// the datapath with command and status structs. Depends on iee_pkg.
`default_nettype none

module iee_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  input  wire iee_pkg::iee_status_t status_i,
  output logic                      s_tready_o,
  output iee_pkg::iee_cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MULDIV = 2'd1;
  localparam logic [1:0] ST_SUM    = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]          state_q, state_d;
  iee_pkg::iee_class_e op_q, op_d;
  logic                accept;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i & s_tready_o;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (status_i.in_class)
            iee_pkg::CLS_DIGIT: begin
              cmd_o.digit_en = 1'b1;
            end
            iee_pkg::CLS_MUL, iee_pkg::CLS_DIV: begin
              cmd_o.set_term_op = 1'b1;
              cmd_o.term_op     = (status_i.in_class == iee_pkg::CLS_DIV) ?
                                  iee_pkg::TERM_OP_DIV : iee_pkg::TERM_OP_MUL;
              op_d              = status_i.in_class;
              if (status_i.term_started) begin
                cmd_o.md_start = 1'b1;
                state_d        = ST_MULDIV;
              end else begin
                cmd_o.load_term = 1'b1;
              end
            end
            iee_pkg::CLS_ADD, iee_pkg::CLS_SUB, iee_pkg::CLS_EQUALS: begin
              op_d = status_i.in_class;
              if (status_i.term_started) begin
                cmd_o.md_start = 1'b1;
                state_d        = ST_MULDIV;
              end else begin
                cmd_o.load_term = 1'b1;
                state_d         = ST_SUM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MULDIV: begin
        if (status_i.md_done) begin
          cmd_o.md_finish = 1'b1;
          // a term operator ends here, a sum operator still folds the term
          if (op_q inside {iee_pkg::CLS_MUL, iee_pkg::CLS_DIV}) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        if (op_q == iee_pkg::CLS_EQUALS) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.set_sum_op = 1'b1;
          cmd_o.sum_op     = (op_q == iee_pkg::CLS_SUB) ?
                             iee_pkg::SUM_OP_SUB : iee_pkg::SUM_OP_ADD;
          state_d          = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= iee_pkg::CLS_OTHER;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: stream ports, controller
// and datapath. Depends on iee_pkg, iee_ctrl and iee_datapath.
//
// Takes one ASCII character per input word and evaluates + - * / with the
// usual precedence, left to right, wrapping at VALUE_WIDTH bits; '=' emits
// one output word (value sign-extended or cut to 32 bits, tuser set if any
// division by zero occurred) and clears the expression. A digit or an
// ignored character is taken straight from the idle state, and so is '*'
// or '/' after the first operand of a term. An operator that closes a
// multiply or divide runs the shared bit-serial multiply / divide unit,
// which skips its iterations for a division by zero. '+' and '-' then pass
// through the sum update state, '=' through sum update and output load.
// The next character is accepted while the output word waits to be taken;
// a second '=' holds only if the output word has not yet been taken.
`default_nettype none

module infix_expression_evaluator #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [iee_pkg::CHAR_WIDTH-1:0]      s_axis_tdata_i,   // [7:0] input_char
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [iee_pkg::RESULT_WIDTH-1:0]         m_axis_tdata_o,   // [31:0] result_value
  output logic                                     m_axis_tuser_o    // [0] divide_error
);

  iee_pkg::iee_cmd_t    cmd;
  iee_pkg::iee_status_t status;

  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .status_i   (status),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  iee_datapath #(
    .W(VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .char_i     (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .status_o   (status),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/iee_checker.sv
// Port-level checks of the infix expression evaluator, bound to its top level.
// Depends on iee_pkg and infix_expression_evaluator.
`default_nettype none

module iee_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [iee_pkg::CHAR_WIDTH-1:0] s_axis_tdata_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [iee_pkg::RESULT_WIDTH-1:0] m_axis_tdata_o,
  input wire logic                           m_axis_tuser_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("output word changed while stalled");

  // no result can appear in the cycle right after a character is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared directly after an accepted character");

  // after a result is loaded the input side is open again
  a_ready_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("input not ready after result load");

  // accepting an end of expression always leaves the controller busy with more work
  a_equals_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tdata_i == iee_pkg::CHAR_EQUALS)) |=> !s_axis_tready_o)
    else $error("input ready right after end of expression");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

>>> dv/infix_expression_evaluator_tb.sv
// Self-checking testbench of infix_expression_evaluator: feeds character streams,
// predicts each '=' word with its own evaluator and checks value and divide flag.
// Depends on iee_pkg and the evaluator RTL.
`default_nettype none

module infix_expression_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned PHASE_CHARS    = 400;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef logic [iee_pkg::CHAR_WIDTH-1:0] char_t;
  typedef logic [VALUE_W-1:0]             value_t;

  typedef struct packed {
    logic [iee_pkg::RESULT_WIDTH-1:0] value;
    logic                             div_err;
  } eval_result_t;

  logic  clk_i           = 1'b0;
  logic  rst_ni          = 1'b0;
  logic  s_axis_tvalid_i = 1'b0;
  char_t s_axis_tdata_i  = '0;
  logic  m_axis_tready_i = 1'b0;
  logic  s_axis_tready_o;
  logic  m_axis_tvalid_o;
  logic [iee_pkg::RESULT_WIDTH-1:0] m_axis_tdata_o;  // [31:0] result_value
  logic  m_axis_tuser_o;                             // [0] divide_error

  infix_expression_evaluator #(
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // [7:0] input_char
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // [31:0] result_value
    .m_axis_tuser_o (m_axis_tuser_o)    // [0] divide_error
  );

  always #2 clk_i = ~clk_i;

  char_t        pending_chars[$];
  eval_result_t expected_results[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned error_count   = 0;
  int unsigned chars_taken   = 0;
  int unsigned words_checked = 0;
  int unsigned div_err_words = 0;
  int unsigned stall_cycles  = 0;
  logic        char_taken    = 1'b0;

  // evaluator state
  value_t sum_acc, term_acc, num_acc;
  logic   term_open, term_op, sum_op, div_zero_seen;

  function automatic void clear_expression();
    sum_acc       = '0;
    term_acc      = '0;
    num_acc       = '0;
    term_open     = 1'b0;
    term_op       = iee_pkg::TERM_OP_MUL;
    sum_op        = iee_pkg::SUM_OP_ADD;
    div_zero_seen = 1'b0;
  endfunction

  // truncating signed divide on magnitudes, so min / -1 wraps back to min
  function automatic value_t signed_quotient(value_t a, value_t b);
    value_t ua, ub, q;
    ua = a[VALUE_W-1] ? -a : a;
    ub = b[VALUE_W-1] ? -b : b;
    if (ub == '0) begin
      div_zero_seen = 1'b1;
      return '1;
    end
    q = ua / ub;
    return (a[VALUE_W-1] != b[VALUE_W-1]) ? -q : q;
  endfunction

  function automatic void fold_operand();
    if (!term_open) begin
      term_acc = num_acc;
    end else if (term_op == iee_pkg::TERM_OP_DIV) begin
      term_acc = signed_quotient(term_acc, num_acc);
    end else begin
      term_acc = term_acc * num_acc;
    end
    term_open = 1'b1;
    num_acc   = '0;
  endfunction

  function automatic void fold_term();
    fold_operand();
    if (sum_op == iee_pkg::SUM_OP_SUB) begin
      sum_acc = sum_acc - term_acc;
    end else begin
      sum_acc = sum_acc + term_acc;
    end
    term_acc  = '0;
    term_open = 1'b0;
    term_op   = iee_pkg::TERM_OP_MUL;
  endfunction

  function automatic void evaluate_char(char_t c);
    eval_result_t res;
    if (c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) begin
      num_acc = num_acc * value_t'(10) + value_t'(c - iee_pkg::CHAR_ZERO);
    end else if (c == iee_pkg::CHAR_MUL || c == iee_pkg::CHAR_DIV) begin
      fold_operand();
      term_op = (c == iee_pkg::CHAR_DIV) ? iee_pkg::TERM_OP_DIV : iee_pkg::TERM_OP_MUL;
    end else if (c == iee_pkg::CHAR_ADD || c == iee_pkg::CHAR_SUB) begin
      fold_term();
      sum_op = (c == iee_pkg::CHAR_SUB) ? iee_pkg::SUM_OP_SUB : iee_pkg::SUM_OP_ADD;
    end else if (c == iee_pkg::CHAR_EQUALS) begin
      fold_term();
      res.value   = sum_acc;
      res.div_err = div_zero_seen;
      expected_results.push_back(res);
      clear_expression();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  // any byte that the evaluator ignores
  function automatic char_t junk_char();
    char_t c;
    do begin
      c = ($urandom_range(99, 0) < 40) ? 8'h20 : char_t'($urandom_range(255, 0));
    end while ((c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) ||
               c == iee_pkg::CHAR_MUL || c == iee_pkg::CHAR_DIV ||
               c == iee_pkg::CHAR_ADD || c == iee_pkg::CHAR_SUB ||
               c == iee_pkg::CHAR_EQUALS);
    return c;
  endfunction

  function automatic char_t operator_char();
    case ($urandom_range(3, 0))
      0:       return iee_pkg::CHAR_MUL;
      1:       return iee_pkg::CHAR_DIV;
      2:       return iee_pkg::CHAR_ADD;
      default: return iee_pkg::CHAR_SUB;
    endcase
  endfunction

  function automatic string operand_text();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) return "";
    if (pick < 20) return "0";
    if (pick < 62) return $sformatf("%0d", $urandom_range(999, 1));
    if (pick < 80) return $sformatf("%0d", $urandom());
    if (pick < 86) return "2147483648";
    if (pick < 92) return "4294967295";
    // may have more digits than fit, and then wraps
    return $sformatf("%0d%0d", $urandom(), $urandom_range(999, 0));
  endfunction

  task automatic push_text(string s, int unsigned junk_pct);
    for (int k = 0; k < s.len(); k++) begin
      if ($urandom_range(99, 0) < junk_pct) pending_chars.push_back(junk_char());
      pending_chars.push_back(char_t'(s[k]));
    end
  endtask

  task automatic push_expression(bit terminated);
    int unsigned n_ops;
    n_ops = $urandom_range(5, 0);
    push_text(operand_text(), 5);
    repeat (n_ops) begin
      // most negative value divided by -1
      if ($urandom_range(99, 0) < 4) push_text("+2147483648/4294967295", 5);
      pending_chars.push_back(operator_char());
      push_text(operand_text(), 5);
    end
    if (terminated) pending_chars.push_back(iee_pkg::CHAR_EQUALS);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned pick;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    while (pending_chars.size() < PHASE_CHARS) begin
      pick = $urandom_range(99, 0);
      if (pick < 82) begin
        push_expression(1'b1);
      end else if (pick < 91) begin
        push_expression(1'b0);
      end else begin
        repeat ($urandom_range(6, 1)) pending_chars.push_back(char_t'($urandom_range(255, 0)));
      end
    end
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || char_taken) begin
        if (pending_chars.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_chars.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99, 0) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    eval_result_t exp_res;
    logic         word_out;
    char_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    word_out   = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (char_taken) begin
      evaluate_char(s_axis_tdata_i);
      chars_taken++;
    end
    if (word_out) begin
      words_checked++;
      if (m_axis_tuser_o) div_err_words++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected output word: value %0d div_err %0b",
                   $signed(m_axis_tdata_o), m_axis_tuser_o);
        end
      end else begin
        exp_res = expected_results.pop_front();
        if (m_axis_tdata_o !== exp_res.value || m_axis_tuser_o !== exp_res.div_err) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch: expected value %0d div_err %0b, got value %0d div_err %0b",
                     $signed(exp_res.value), exp_res.div_err,
                     $signed(m_axis_tdata_o), m_axis_tuser_o);
          end
        end
      end
    end
    stall_cycles = (char_taken || word_out) ? 0 : stall_cycles + 1;
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    do @(posedge clk_i); while (stall_cycles < WATCHDOG_LIMIT);
    $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_expression();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: leading minus, all four operators with an empty operand,
    // divide by zero among ignored bytes, and an empty expression
    push_text("-5=", 0);
    push_text("9*-3/2+1=", 0);
    push_text("7/0 ", 0);
    pending_chars.push_back(8'hFF);
    pending_chars.push_back(8'h00);
    pending_chars.push_back(iee_pkg::CHAR_EQUALS);
    pending_chars.push_back(iee_pkg::CHAR_EQUALS);

    run_phase(0, 0);
    run_phase(46, 0);
    run_phase(0, 46);
    run_phase(28, 28);

    while (s_axis_tvalid_i || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $display("%0d expected words never arrived", expected_results.size());
    end

    $display("evaluated %0d characters across four idle/stall mixes", chars_taken);
    $display("checked %0d result words, %0d of them flagged divide by zero",
             words_checked, div_err_words);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> infix_expression_evaluator.f
rtl/core/iee_pkg.sv
rtl/core/iee_muldiv.sv
rtl/core/iee_datapath.sv
rtl/core/iee_ctrl.sv
rtl/core/infix_expression_evaluator.sv
rtl/core/iee_checker.sv
dv/infix_expression_evaluator_tb.sv
